@@ hw/rtl/lud_pkg.sv @@
// ----------------------------------------------------------------------------
// lud_pkg
// Shared constants, types and saturation helper for the LU decomposition block.
// ----------------------------------------------------------------------------
package lud_pkg;

    // matrix geometry
    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int DIM_W     = 4;
    localparam int OUT_IDX_W = 3;

    // Q16.16 data
    localparam int          DATA_W  = 32;
    localparam int          FRAC_W  = 16;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // divider: 48-bit magnitude dividend, one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // output word layout
    localparam int TDATA_W = 104;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic        ovf;
    } t_div_res;

    // clamp a wide signed value into the signed 32-bit range
    function automatic t_sat sat32(input logic signed [48:0] v);
        t_sat r;
        r.ovf = 1'b1;
        if (v > 49'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
        end else if (v < -(49'sd2147483648)) begin
            r.val = 32'h8000_0000;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lu_decompose_doolittle.sv @@
// ----------------------------------------------------------------------------
// lu_decompose_doolittle
// Doolittle LU reduction without pivoting, Q16.16, memory-based sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Set the matrix size with i_cfg_we/i_cfg_data (0 reads as 1, above 8 as 8);
//   a write also restarts loading. Then stream n*n entries on s_axis, outer
//   index first, one word per cycle. After the last entry s_axis_tready drops
//   while the matrix is reduced in the U memory; factors go to the L memory.
//   Each pivot/column pair runs through the bit-serial divider and then a
//   read-multiply-subtract-write pass over every row, all on one read port
//   of the U memory; the determinant is the product of the diagonal entries.
//   Then n*n words leave on m_axis in load order, each going through memory
//   read, output register and handshake before the next is read, with tlast
//   on the final one.
//   A stalled receiver simply holds the output word; nothing is lost.
//   Reset (synchronous, active low) sets n = 8, clears the load position and
//   flags, and leaves the block ready for input. Memories are not cleared.
// ----------------------------------------------------------------------------
module lu_decompose_doolittle (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lud_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // [31:0] entry_value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] outer_index, [5:3] inner_index, [37:6] lower_value,
    // [69:38] upper_value, [101:70] determinant, [102] singular, [103] overflowed
    output logic [lud_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast
);

    typedef enum logic [3:0] {
        S_LOAD, S_DIV_RDP, S_DIV_RDJ, S_DIV_START, S_DIV_WAIT,
        S_K_RDP, S_K_RDJ, S_K_MUL, S_K_SUB,
        S_DET_RD, S_DET_MUL, S_DET_SAT,
        S_OUT_RD, S_OUT_CAP, S_OUT_WAIT
    } t_state;

    localparam int IW = lud_pkg::IDX_W;

    t_state                      r_state;
    logic [lud_pkg::DIM_W-1:0]   r_dim;
    logic [IW-1:0]               r_row, r_col;
    logic [IW-1:0]               r_p, r_j, r_k;
    logic [31:0]                 r_piv, r_f, r_x, r_y, r_det;
    logic signed [63:0]          r_prod;
    logic                        r_sing, r_ovf;
    logic                        r_valid, r_last;
    logic [lud_pkg::TDATA_W-1:0] r_tdata;

    logic [lud_pkg::DIM_W:0]     eff_n;
    logic [IW-1:0]               n_last;
    logic                        in_acc;

    logic                        u_we;
    logic [lud_pkg::ADDR_W-1:0]  u_waddr, u_raddr;
    logic [31:0]                 u_wdata, u_rdata;
    logic                        l_we;
    logic [31:0]                 l_wdata, l_rdata;

    logic signed [31:0]          mul_a, mul_b;
    lud_pkg::t_sat               q_sat, d_sat;
    logic [31:0]                 lower_out;

    lud_pkg::t_div_req           div_req;
    lud_pkg::t_div_res           div_res;

    // active size, clamped
    always_comb begin
        if (r_dim == '0) begin
            eff_n = (lud_pkg::DIM_W + 1)'(1);
        end else if ({1'b0, r_dim} > (lud_pkg::DIM_W + 1)'(lud_pkg::MAX_DIM)) begin
            eff_n = (lud_pkg::DIM_W + 1)'(lud_pkg::MAX_DIM);
        end else begin
            eff_n = {1'b0, r_dim};
        end
    end
    assign n_last = IW'(eff_n - 1'b1);

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // U memory ports
    always_comb begin
        unique case (r_state)
            S_DIV_RDP: u_raddr = {r_p, r_p};
            S_DIV_RDJ: u_raddr = {r_p, r_j};
            S_K_RDP:   u_raddr = {r_k, r_p};
            S_K_RDJ:   u_raddr = {r_k, r_j};
            S_DET_RD:  u_raddr = {r_k, r_k};
            default:   u_raddr = {r_row, r_col};
        endcase
    end
    assign u_we    = in_acc || (r_state == S_K_SUB);
    assign u_waddr = (r_state == S_K_SUB) ? {r_k, r_j} : {r_row, r_col};
    assign u_wdata = (r_state == S_K_SUB) ? d_sat.val : s_axis_tdata;

    // L memory: factors above the diagonal
    assign l_we    = ((r_state == S_DIV_START) && (r_piv == '0)) ||
                     ((r_state == S_DIV_WAIT) && div_res.done);
    assign l_wdata = (r_state == S_DIV_WAIT) ? div_res.quo : '0;

    lud_ram #(.WIDTH(32), .DEPTH(lud_pkg::RAM_DEPTH)) u_upper (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(u_waddr),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    lud_ram #(.WIDTH(32), .DEPTH(lud_pkg::RAM_DEPTH)) u_lower (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr({r_p, r_j}),
        .i_wdata(l_wdata),
        .i_raddr({r_row, r_col}),
        .o_rdata(l_rdata)
    );

    // divider
    assign div_req.start = (r_state == S_DIV_START) && (r_piv != '0);
    assign div_req.num   = u_rdata;
    assign div_req.den   = r_piv;

    lud_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_res  (div_res)
    );

    // shared multiplier operands
    assign mul_a = (r_state == S_DET_MUL) ? $signed(r_det)   : $signed(r_f);
    assign mul_b = (r_state == S_DET_MUL) ? $signed(u_rdata) : $signed(r_x);

    // floor(prod / 2^16), clamped; then y - t, clamped
    assign q_sat = lud_pkg::sat32({r_prod[63], r_prod[63:16]});
    assign d_sat = lud_pkg::sat32(49'($signed({r_y[31], r_y}) -
                                      $signed({q_sat.val[31], q_sat.val})));

    // L value at the output position: unit diagonal, zero below
    always_comb begin
        if (r_row == r_col) begin
            lower_out = lud_pkg::ONE_Q16;
        end else if (r_col > r_row) begin
            lower_out = l_rdata;
        end else begin
            lower_out = '0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dim   <= lud_pkg::DIM_W'(lud_pkg::MAX_DIM);
            r_row   <= '0;
            r_col   <= '0;
            r_p     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_sing  <= 1'b0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_col == n_last) begin
                            r_col <= '0;
                            if (r_row == n_last) begin
                                r_row  <= '0;
                                r_sing <= 1'b0;
                                r_ovf  <= 1'b0;
                                r_det  <= lud_pkg::ONE_Q16;
                                r_p    <= '0;
                                r_j    <= IW'(1);
                                r_k    <= '0;
                                r_state <= (n_last == '0) ? S_DET_RD : S_DIV_RDP;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_DIV_RDP: begin
                    r_state <= S_DIV_RDJ;
                end
                S_DIV_RDJ: begin
                    r_piv   <= u_rdata;
                    r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    if (r_piv == '0) begin
                        r_sing  <= 1'b1;
                        r_f     <= '0;
                        r_k     <= '0;
                        r_state <= S_K_RDP;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_res.done) begin
                        r_f     <= div_res.quo;
                        r_ovf   <= r_ovf | div_res.ovf;
                        r_k     <= '0;
                        r_state <= S_K_RDP;
                    end
                end
                S_K_RDP: begin
                    r_state <= S_K_RDJ;
                end
                S_K_RDJ: begin
                    r_x     <= u_rdata;
                    r_state <= S_K_MUL;
                end
                S_K_MUL: begin
                    r_y     <= u_rdata;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_K_SUB;
                end
                S_K_SUB: begin
                    r_ovf <= r_ovf | q_sat.ovf | d_sat.ovf;
                    if (r_k != n_last) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_K_RDP;
                    end else if (r_j != n_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_DIV_RDP;
                    end else if (IW'(r_p + 1'b1) != n_last) begin
                        r_p     <= r_p + 1'b1;
                        r_j     <= IW'(r_p + 2'd2);
                        r_state <= S_DIV_RDP;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_DET_RD;
                    end
                end
                S_DET_RD: begin
                    r_state <= S_DET_MUL;
                end
                S_DET_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_DET_SAT;
                end
                S_DET_SAT: begin
                    r_det <= q_sat.val;
                    r_ovf <= r_ovf | q_sat.ovf;
                    if (r_k == n_last) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DET_RD;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_CAP;
                end
                S_OUT_CAP: begin
                    r_tdata <= {r_ovf, r_sing, r_det, u_rdata, lower_out,
                                lud_pkg::OUT_IDX_W'(r_col), lud_pkg::OUT_IDX_W'(r_row)};
                    r_last  <= (r_row == n_last) && (r_col == n_last);
                    r_valid <= 1'b1;
                    r_state <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_axis_tready) begin
                        r_valid <= 1'b0;
                        if (r_col == n_last) begin
                            r_col <= '0;
                            if (r_row == n_last) begin
                                r_row   <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_state <= S_OUT_RD;
                            end
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            // size write restarts loading
            if (i_cfg_we) begin
                r_dim <= i_cfg_data;
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_last;

endmodule

@@ hw/rtl/lud_ram.sv @@
// ----------------------------------------------------------------------------
// lud_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lud_div.sv @@
// ----------------------------------------------------------------------------
// lud_div
// Q16.16 divider: (num * 2^16) / den truncated toward zero, saturated.
// Restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lud_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lud_pkg::t_div_req i_req,
    output lud_pkg::t_div_res o_res
);

    logic                              r_busy;
    logic                              r_done;
    logic [lud_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [31:0]                       r_rem;
    logic [lud_pkg::DIV_STEPS-1:0]     r_dvd;
    logic [lud_pkg::DIV_STEPS-1:0]     r_quo;
    logic [31:0]                       r_den;
    logic                              r_neg;

    logic [32:0]         rem_sh;
    logic                rem_ge;
    logic [32:0]         rem_nx;
    logic [31:0]         num_abs;
    logic [31:0]         den_abs;
    logic signed [48:0]  quo_signed;
    lud_pkg::t_sat       quo_sat;

    // magnitudes of the operands
    assign num_abs = i_req.num[31] ? (~i_req.num + 32'd1) : i_req.num;
    assign den_abs = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;

    // one restoring step
    assign rem_sh = {r_rem, r_dvd[lud_pkg::DIV_STEPS-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= {num_abs, {lud_pkg::FRAC_W{1'b0}}};
                r_quo  <= '0;
                r_den  <= den_abs;
                r_neg  <= i_req.num[31] ^ i_req.den[31];
            end else if (r_busy) begin
                r_rem <= rem_nx[31:0];
                r_dvd <= {r_dvd[lud_pkg::DIV_STEPS-2:0], 1'b0};
                r_quo <= {r_quo[lud_pkg::DIV_STEPS-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lud_pkg::DIV_CNT_W'(lud_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // apply sign and clamp
    assign quo_signed = r_neg ? (49'sd0 - $signed({1'b0, r_quo})) : $signed({1'b0, r_quo});
    assign quo_sat    = lud_pkg::sat32(quo_signed);

    assign o_res.done = r_done;
    assign o_res.quo  = quo_sat.val;
    assign o_res.ovf  = quo_sat.ovf;

endmodule

@@ hw/rtl/lud_chk.sv @@
// ----------------------------------------------------------------------------
// lud_chk
// Port-level checks for lu_decompose_doolittle, bound to the top level.
// ----------------------------------------------------------------------------
module lud_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [lud_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // loading and emitting never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output valid");

    // after the final word the block returns to loading
    a_tlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after final word");

    // reset leaves the block ready for input with no output pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("bad state after reset");

endmodule

bind lu_decompose_doolittle lud_chk u_lud_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
